// File: rtl/wbps_pkg.sv
// Shared types and constants of the wildcard byte pattern search unit.
package wbps_pkg;

    // Input item command codes.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    // Result status codes.
    localparam logic STATUS_FOUND     = 1'b0;
    localparam logic STATUS_NOT_FOUND = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS   = 1'd1;

    // Fixed field widths.
    localparam int LEN_W   = 7;
    localparam int INDEX_W = 6;
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 64;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // write one pattern entry
        logic shift;      // advance the partial-match vector by one byte
        logic advance;    // step the byte offset
        logic clear;      // clear the scan state for the next region
        logic capture;    // load the result register
        logic found;      // result is a match (otherwise not found)
    } wbps_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;        // the current byte completes a full match
    } wbps_status_t;

endpackage

// File: rtl/wildcard_byte_pattern_search_unit.sv
// Top level of the wildcard byte pattern search unit.
//
// This block scans a streamed byte region for the first place where a pattern of up to
// PATTERN_MAX bytes matches, where any pattern position may be a wildcard. Load items
// (s_cmd 0) write one pattern entry each; data items (s_cmd 1) carry one region byte, with
// s_data_last on the final byte. Every pattern position used by pattern_length must be
// loaded before a region is scanned. On the first full match the block returns status 0 and
// base_address plus the match start offset, then ignores the rest of the region; a region
// that ends without a match returns status 1 and address zero. The bank of per-position
// byte comparators and the partial-match shift vector handle one byte per cycle, so the
// unit sustains one item per cycle while it is not stalled. The input stalls only while a
// result sits in the output register and the consumer holds m_ready low.
// Configuration writes (index 0 pattern_length, index 1 base_address) take effect at once
// and are meant to be made only while no item is in flight.
module wildcard_byte_pattern_search_unit
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX = 64,
    parameter int OFFSET_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write port.
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_wdata,
    // Input item channel.
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_cmd,
    input  logic [INDEX_W-1:0]   s_entry_index,
    input  logic [BYTE_W-1:0]    s_entry_value,
    input  logic                 s_entry_wildcard,
    input  logic [BYTE_W-1:0]    s_data_byte,
    input  logic                 s_data_last,
    // Result item channel.
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_status,
    output logic [ADDR_W-1:0]    m_match_address
);

    wbps_cmd_t    dp_cmd;
    wbps_status_t dp_status;

    // The controller runs the handshakes and remembers whether the current region has
    // already produced its match, in which case later bytes are dropped until the last one.
    wbps_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_data_last (s_data_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .dp_status   (dp_status),
        .dp_cmd      (dp_cmd)
    );

    // The datapath holds the pattern, the partial-match vector, the byte offset, the
    // configuration registers and the result register.
    wbps_dp #(
        .PATTERN_MAX (PATTERN_MAX),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_entry_index    (s_entry_index),
        .s_entry_value    (s_entry_value),
        .s_entry_wildcard (s_entry_wildcard),
        .s_data_byte      (s_data_byte),
        .dp_cmd           (dp_cmd),
        .dp_status        (dp_status),
        .m_status         (m_status),
        .m_match_address  (m_match_address)
    );

endmodule

// File: rtl/wbps_ctrl.sv
// Controller of the wildcard byte pattern search unit: handshakes and scan state.
module wbps_ctrl
    import wbps_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         s_cmd,
    input  logic         s_data_last,
    output logic         m_valid,
    input  logic         m_ready,
    input  wbps_status_t dp_status,
    output wbps_cmd_t    dp_cmd
);

    typedef enum logic {
        ST_SCAN,
        ST_SKIP
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   take_byte;

    assign s_ready   = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign take_byte = s_valid && s_ready && (s_cmd == CMD_DATA);

    always_comb begin
        state_next     = state_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        dp_cmd         = '0;
        dp_cmd.load    = s_valid && s_ready && (s_cmd == CMD_LOAD);
        case (state_reg)
            ST_SCAN: begin
                if (take_byte) begin
                    dp_cmd.shift = 1'b1;
                    if (dp_status.hit) begin
                        dp_cmd.capture = 1'b1;
                        dp_cmd.found   = 1'b1;
                        m_valid_next   = 1'b1;
                        if (s_data_last) begin
                            dp_cmd.clear = 1'b1;
                        end else begin
                            state_next = ST_SKIP;
                        end
                    end else if (s_data_last) begin
                        dp_cmd.capture = 1'b1;
                        dp_cmd.clear   = 1'b1;
                        m_valid_next   = 1'b1;
                    end else begin
                        dp_cmd.advance = 1'b1;
                    end
                end
            end
            ST_SKIP: begin
                if (take_byte && s_data_last) begin
                    dp_cmd.clear = 1'b1;
                    state_next   = ST_SCAN;
                end
            end
            default: begin
                state_next = ST_SCAN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_SCAN;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: rtl/wbps_dp.sv
// Datapath of the wildcard byte pattern search unit: pattern, match vector, offset, result.
module wbps_dp
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX = 64,
    parameter int OFFSET_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_wdata,
    input  logic [INDEX_W-1:0]   s_entry_index,
    input  logic [BYTE_W-1:0]    s_entry_value,
    input  logic                 s_entry_wildcard,
    input  logic [BYTE_W-1:0]    s_data_byte,
    input  wbps_cmd_t            dp_cmd,
    output wbps_status_t         dp_status,
    output logic                 m_status,
    output logic [ADDR_W-1:0]    m_match_address
);

    localparam int PTR_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    // Pattern entries: undefined until loaded, compared in parallel every byte.
    logic [BYTE_W-1:0]      pat_value_reg [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] pat_wild_reg;

    logic [PATTERN_MAX-1:0] pm_reg, pm_next;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [LEN_W-1:0]       len_reg;
    logic [ADDR_W-1:0]      base_reg;
    logic                   status_reg;
    logic [ADDR_W-1:0]      addr_reg;

    logic [PATTERN_MAX-1:0] eq;
    logic [PTR_W-1:0]       top;
    logic [OFFSET_BITS-1:0] start;
    logic [ADDR_W-1:0]      hit_addr;

    // Per-position byte comparators.
    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            eq[i] = pat_wild_reg[i] || (pat_value_reg[i] == s_data_byte);
        end
    end

    assign pm_next = PATTERN_MAX'({pm_reg, 1'b1}) & eq;

    // Index of the last pattern position in use; length is clamped to 1..PATTERN_MAX.
    always_comb begin
        if (len_reg == '0) begin
            top = '0;
        end else if (int'(len_reg) > PATTERN_MAX) begin
            top = PTR_W'(PATTERN_MAX - 1);
        end else begin
            top = PTR_W'(int'(len_reg) - 1);
        end
    end

    assign dp_status.hit = pm_next[top];
    assign start         = offset_reg - OFFSET_BITS'(top);
    assign hit_addr      = base_reg + ADDR_W'(start);

    always_ff @(posedge aclk) begin
        if (dp_cmd.load && (int'(s_entry_index) < PATTERN_MAX)) begin
            pat_value_reg[PTR_W'(s_entry_index)] <= s_entry_value;
            pat_wild_reg[PTR_W'(s_entry_index)]  <= s_entry_wildcard;
        end
        if (dp_cmd.capture) begin
            status_reg <= dp_cmd.found ? STATUS_FOUND : STATUS_NOT_FOUND;
            addr_reg   <= dp_cmd.found ? hit_addr : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pm_reg     <= '0;
            offset_reg <= '0;
            len_reg    <= LEN_W'(1);
            base_reg   <= '0;
        end else begin
            if (dp_cmd.clear) begin
                pm_reg     <= '0;
                offset_reg <= '0;
            end else begin
                if (dp_cmd.shift) begin
                    pm_reg <= pm_next;
                end
                if (dp_cmd.advance) begin
                    offset_reg <= offset_reg + OFFSET_BITS'(1);
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_PATTERN_LENGTH: len_reg  <= cfg_wdata[LEN_W-1:0];
                    REG_BASE_ADDRESS:   base_reg <= cfg_wdata;
                    default:            ;
                endcase
            end
        end
    end

    assign m_status        = status_reg;
    assign m_match_address = addr_reg;

endmodule

// File: rtl/wbps_check.sv
// Port-level assertions for the wildcard byte pattern search unit, with their bind.
module wbps_check
    import wbps_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              s_cmd,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_status,
    input logic [ADDR_W-1:0] m_match_address
);

    // A waiting result holds until it is taken.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_match_address))
        else $error("result changed while stalled");

    // A not-found result always carries address zero.
    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STATUS_NOT_FOUND) |-> m_match_address == '0)
        else $error("not-found result with nonzero address");

    // With no result pending the block always takes input.
    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no result pending");

    // A new result only follows an accepted data item.
    a_result_from_data: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid ##1 m_valid |-> $past(s_valid && s_ready && (s_cmd == CMD_DATA)))
        else $error("result without a data item");

endmodule

bind wildcard_byte_pattern_search_unit wbps_check u_wbps_check (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_cmd           (s_cmd),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_match_address (m_match_address)
);
